// File: hw/rtl/mcc_pkg.sv
// mcc_pkg: types, codes and scaling constants of the mppt charge controller
// used by mcc_seru and mppt_charge_controller; depends on nothing
package mcc_pkg;

	// width of the shared serial multiply / divide unit
	localparam int ALU_W = 40;

	typedef enum logic {
		OP_MUL,
		OP_DIV
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} alu_req_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ISSUE,
		S_WAIT,
		S_DECIDE,
		S_OUT
	} state_t;

	// micro-steps of the per-item program
	typedef enum logic [4:0] {
		P_VIN_MUL,
		P_VIN_DIV,
		P_VIN_MUL2,
		P_VIN_DIV2,
		P_DRP_MUL,
		P_DRP_DIV,
		P_DRP_MUL2,
		P_DRP_DIV2,
		P_CUR_MUL,
		P_CUR_DIV,
		P_FMA_DIV,
		P_FOUT_DIV,
		P_OMA_MUL,
		P_OMA_DIV,
		P_BAT_DIV,
		P_PWR_MUL,
		P_PWR_DIV,
		P_EGY_MUL,
		P_EGY_DIV
	} step_t;

	// register indexes
	localparam logic [3:0] REG_MIN_DUTY   = 4'd0;
	localparam logic [3:0] REG_MAX_DUTY   = 4'd1;
	localparam logic [3:0] REG_MAX_POWER  = 4'd2;
	localparam logic [3:0] REG_CUTOFF     = 4'd3;
	localparam logic [3:0] REG_WARN       = 4'd4;
	localparam logic [3:0] REG_CTL_IVL    = 4'd5;
	localparam logic [3:0] REG_BACKOFF    = 4'd6;
	localparam logic [3:0] REG_FAIL_LIMIT = 4'd7;

	// modes
	localparam logic [3:0] MODE_NORMAL   = 4'd0;
	localparam logic [3:0] MODE_TAPER1   = 4'd1;
	localparam logic [3:0] MODE_TAPER2   = 4'd2;
	localparam logic [3:0] MODE_TAPER3   = 4'd3;
	localparam logic [3:0] MODE_TAPER4   = 4'd4;
	localparam logic [3:0] MODE_LOW_WARN = 4'd6;
	localparam logic [3:0] MODE_NO_INPUT = 4'd7;
	localparam logic [3:0] MODE_MAX_PWR  = 4'd8;

	// scaling
	localparam int K_VIN_MUL  = 13072;
	localparam int K_VIN_DIV  = 3266;
	localparam int K_DIV_MUL  = 4998;
	localparam int K_ADC_FS   = 1023;
	localparam int K_DRP_MUL  = 14698;
	localparam int K_DRP_DIV  = 4900;
	localparam int K_CUR_MUL  = 51098;
	localparam int K_CUR_ZERO = 512;
	localparam int K_DECAY    = 31;
	localparam int K_MILLI    = 1000;
	localparam int K_HOUR_S   = 3600;
	localparam int K_BATT_MAX = 32767;

	// taper thresholds (mV) and power limits (mW)
	localparam logic [14:0] TAPER4_MV = 15'd4120;
	localparam logic [14:0] TAPER3_MV = 15'd4100;
	localparam logic [14:0] TAPER2_MV = 15'd4050;
	localparam logic [14:0] TAPER1_MV = 15'd3980;
	localparam logic [19:0] TAPER4_MW = 20'd28;
	localparam logic [19:0] TAPER3_MW = 20'd1220;
	localparam logic [19:0] TAPER2_MW = 20'd2800;
	localparam logic [19:0] TAPER1_MW = 20'd6000;

endpackage

// File: hw/rtl/mcc_seru.sv
// mcc_seru: bit-serial signed multiply and truncating divide, one bit a cycle
// depends on mcc_pkg (op_t, alu_req_t)
module mcc_seru #(
	parameter int W = 40
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mcc_pkg::alu_req_t   req,
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	output logic                done,
	output logic signed [W-1:0] res
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  acc_q, sh_q, bb_q;
	logic          neg_q, zero_q, run_q, done_q;
	mcc_pkg::op_t  op_q;
	logic [CW-1:0] cnt_q;
	logic signed [W-1:0] res_q;

	logic [W-1:0] ma, mb, acc_n, sh_n, bb_n, rem, mag;
	logic         ge;

	assign ma = a[W-1] ? W'(-a) : W'(a);
	assign mb = b[W-1] ? W'(-b) : W'(b);

	always_comb begin
		rem = {acc_q[W-2:0], sh_q[W-1]};
		ge  = rem >= bb_q;
		if (op_q == mcc_pkg::OP_MUL) begin
			acc_n = sh_q[0] ? acc_q + bb_q : acc_q;
			sh_n  = sh_q >> 1;
			bb_n  = bb_q << 1;
			mag   = acc_n;
		end else begin
			acc_n = ge ? rem - bb_q : rem;
			sh_n  = {sh_q[W-2:0], ge};
			bb_n  = bb_q;
			mag   = zero_q ? '0 : sh_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(W);
		end else if (run_q) begin
			cnt_q  <= cnt_q - 1'b1;
			run_q  <= cnt_q != CW'(1);
			done_q <= cnt_q == CW'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q  <= '0;
			sh_q   <= ma;
			bb_q   <= mb;
			neg_q  <= a[W-1] ^ b[W-1];
			zero_q <= mb == '0;
			op_q   <= req.op;
		end else if (run_q) begin
			acc_q <= acc_n;
			sh_q  <= sh_n;
			bb_q  <= bb_n;
			if (cnt_q == CW'(1))
				res_q <= neg_q ? -signed'(mag) : signed'(mag);
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// File: hw/rtl/mppt_charge_controller.sv
// mppt_charge_controller: perturb-and-observe charge controller, top level
// depends on mcc_pkg and mcc_seru (shared bit-serial multiply / divide)
// runs 15 serial operations per item on the shared unit; an item that
//   makes a control decision runs 4 more
// one item at a time: the next item is taken once the result is in the output register
// reset: arst_n clears control, filter and configuration state at once, no clearing pass
module mppt_charge_controller #(
	parameter int ENERGY_BITS = 48,
	parameter int TIME_BITS   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // time_ms, adc_input_v, adc_current, adc_drop
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	// duty, mode, power_mw, input_mv, input_ma, battery_mv, energy_uwh, increasing
	output logic [((79 + ENERGY_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [19:0] cfg_data
);

	localparam int W     = mcc_pkg::ALU_W;
	localparam int OUT_W = ((79 + ENERGY_BITS + 7) / 8) * 8;

	// configuration registers
	logic [7:0]  min_duty_q, max_duty_q;
	logic [19:0] max_power_q, backoff_q;
	logic [15:0] cutoff_q, warn_q, ctl_ivl_q;
	logic [3:0]  fail_limit_q;

	// latched input item
	logic [31:0] time_q;
	logic [9:0]  adc_v_q, adc_i_q, adc_d_q;

	// controller state
	logic signed [16:0] fin_mv_q, fin_ma_q, fout_q;
	logic [7:0]  duty_q;
	logic [19:0] power_q, hist_a_q, hist_b_q;
	logic        step_up_q;
	logic signed [4:0] fail_q;
	logic [3:0]  mode_q;
	logic [TIME_BITS-1:0]   last_ctl_q, last_bo_q;
	logic [ENERGY_BITS-1:0] energy_q;

	// scratch of the program
	logic signed [W-1:0] t_q;
	logic signed [15:0]  in_mv_q;
	logic signed [16:0]  out_mv_q, cur_ma_q;
	logic [14:0]         batt_q;

	mcc_pkg::state_t state_q, state_n;
	mcc_pkg::step_t  step_q;

	logic               m_tvalid_q;
	logic [OUT_W-1:0]   m_tdata_q;

	// serial unit hookup
	mcc_pkg::alu_req_t   req;
	logic signed [W-1:0] opa, opb, res;
	logic                done;

	mcc_seru #(.W(W)) u_seru (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.a     (opa),
		.b     (opb),
		.done  (done),
		.res   (res)
	);

	// interval checks
	logic [TIME_BITS-1:0] now, ctl_elapsed, bo_elapsed;
	logic                 ctl_due, bo_due;

	assign now         = TIME_BITS'(time_q);
	assign ctl_elapsed = now - last_ctl_q;
	assign bo_elapsed  = now - last_bo_q;
	assign ctl_due     = 64'(ctl_elapsed) >= 64'(ctl_ivl_q);
	assign bo_due      = 64'(bo_elapsed) >= 64'(backoff_q);

	// operand selection per micro-step
	logic signed [W-1:0] fma_w, fout_w, t_w;
	logic                mul_op;

	assign fma_w  = W'(fin_ma_q);
	assign fout_w = W'(fout_q);
	assign t_w    = t_q;

	always_comb begin
		opa    = t_w;
		opb    = W'(mcc_pkg::K_ADC_FS);
		mul_op = 1'b0;
		unique case (step_q)
			mcc_pkg::P_VIN_MUL: begin
				opa    = W'({1'b0, adc_v_q});
				opb    = W'(mcc_pkg::K_VIN_MUL);
				mul_op = 1'b1;
			end
			mcc_pkg::P_VIN_DIV:  opb = W'(mcc_pkg::K_VIN_DIV);
			mcc_pkg::P_VIN_MUL2: begin
				opb    = W'(mcc_pkg::K_DIV_MUL);
				mul_op = 1'b1;
			end
			mcc_pkg::P_VIN_DIV2: opb = W'(mcc_pkg::K_ADC_FS);
			mcc_pkg::P_DRP_MUL: begin
				opa    = W'({1'b0, adc_d_q});
				opb    = W'(mcc_pkg::K_DRP_MUL);
				mul_op = 1'b1;
			end
			mcc_pkg::P_DRP_DIV:  opb = W'(mcc_pkg::K_DRP_DIV);
			mcc_pkg::P_DRP_MUL2: begin
				opb    = W'(mcc_pkg::K_DIV_MUL);
				mul_op = 1'b1;
			end
			mcc_pkg::P_DRP_DIV2: opb = W'(mcc_pkg::K_ADC_FS);
			mcc_pkg::P_CUR_MUL: begin
				opa    = W'({1'b0, adc_i_q}) - W'(mcc_pkg::K_CUR_ZERO);
				opb    = W'(mcc_pkg::K_CUR_MUL);
				mul_op = 1'b1;
			end
			mcc_pkg::P_CUR_DIV:  opb = W'(mcc_pkg::K_ADC_FS);
			// 30x + new, decayed by 31
			mcc_pkg::P_FMA_DIV: begin
				opa = (fma_w <<< 5) - (fma_w <<< 1) + W'(cur_ma_q);
				opb = W'(mcc_pkg::K_DECAY);
			end
			mcc_pkg::P_FOUT_DIV: begin
				opa = (fout_w <<< 5) - (fout_w <<< 1) + W'(out_mv_q);
				opb = W'(mcc_pkg::K_DECAY);
			end
			mcc_pkg::P_OMA_MUL: begin
				opa    = fma_w;
				opb    = W'(fin_mv_q);
				mul_op = 1'b1;
			end
			// zero output voltage gives zero current through the unit
			mcc_pkg::P_OMA_DIV:  opb = fout_w;
			mcc_pkg::P_BAT_DIV: begin
				opa = (t_w <<< 5) - (t_w <<< 1);
				opb = W'(mcc_pkg::K_MILLI);
			end
			mcc_pkg::P_PWR_MUL: begin
				opa    = W'(fin_mv_q);
				opb    = fma_w;
				mul_op = 1'b1;
			end
			mcc_pkg::P_PWR_DIV:  opb = W'(mcc_pkg::K_MILLI);
			mcc_pkg::P_EGY_MUL: begin
				opa    = W'({1'b0, power_q});
				opb    = W'({1'b0, ctl_ivl_q});
				mul_op = 1'b1;
			end
			mcc_pkg::P_EGY_DIV:  opb = W'(mcc_pkg::K_HOUR_S);
			default: ;
		endcase
	end

	// battery estimate, clamped
	logic signed [W-1:0] batt_w;
	logic [14:0]         batt_c;

	assign batt_w = fout_w - res;
	always_comb begin
		if (batt_w < 0)
			batt_c = '0;
		else if (batt_w > W'(mcc_pkg::K_BATT_MAX))
			batt_c = 15'(mcc_pkg::K_BATT_MAX);
		else
			batt_c = batt_w[14:0];
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			mcc_pkg::S_IDLE:  if (s_tvalid) state_n = mcc_pkg::S_ISSUE;
			mcc_pkg::S_ISSUE: state_n = mcc_pkg::S_WAIT;
			mcc_pkg::S_WAIT: begin
				if (done) begin
					if (step_q == mcc_pkg::P_BAT_DIV)
						state_n = ctl_due ? mcc_pkg::S_ISSUE : mcc_pkg::S_OUT;
					else if (step_q == mcc_pkg::P_EGY_DIV)
						state_n = mcc_pkg::S_DECIDE;
					else
						state_n = mcc_pkg::S_ISSUE;
				end
			end
			mcc_pkg::S_DECIDE: state_n = mcc_pkg::S_OUT;
			mcc_pkg::S_OUT:    if (!m_tvalid_q || m_tready) state_n = mcc_pkg::S_IDLE;
			default:           state_n = mcc_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready  = state_q == mcc_pkg::S_IDLE;
		req.start = state_q == mcc_pkg::S_ISSUE;
		req.op    = mul_op ? mcc_pkg::OP_MUL : mcc_pkg::OP_DIV;
	end

	// mode decision, reads the freshly computed power
	logic [7:0]        d_duty;
	logic [3:0]        d_mode;
	logic              d_step_up, d_bo_hit, ret, drop;
	logic signed [5:0] fc, lim;
	logic [19:0]       limit_mw;

	always_comb begin
		d_duty    = duty_q;
		d_mode    = mode_q;
		d_step_up = step_up_q;
		d_bo_hit  = 1'b0;
		fc        = 6'(fail_q);
		lim       = signed'({2'b00, fail_limit_q});
		limit_mw  = '0;
		ret       = 1'b0;
		drop      = hist_b_q > power_q || hist_a_q > power_q;
		priority if (power_q >= max_power_q) begin
			d_mode = mcc_pkg::MODE_MAX_PWR;
			if (d_duty > min_duty_q) d_duty = d_duty - 1'b1;
		end else if (18'(fin_mv_q) <= signed'({2'b00, cutoff_q})) begin
			d_mode = mcc_pkg::MODE_NO_INPUT;
			d_duty = min_duty_q;
		end else if (18'(fin_mv_q) <= signed'({2'b00, warn_q})) begin
			if (bo_due) begin
				d_bo_hit = 1'b1;
				d_duty   = min_duty_q;
			end
			d_mode = mcc_pkg::MODE_LOW_WARN;
			if (d_duty > min_duty_q) d_duty = d_duty - 1'b1;
		end else begin
			priority if (batt_q >= mcc_pkg::TAPER4_MV) begin
				d_mode = mcc_pkg::MODE_TAPER4; limit_mw = mcc_pkg::TAPER4_MW;
			end else if (batt_q >= mcc_pkg::TAPER3_MV) begin
				d_mode = mcc_pkg::MODE_TAPER3; limit_mw = mcc_pkg::TAPER3_MW;
			end else if (batt_q >= mcc_pkg::TAPER2_MV) begin
				d_mode = mcc_pkg::MODE_TAPER2; limit_mw = mcc_pkg::TAPER2_MW;
			end else if (batt_q >= mcc_pkg::TAPER1_MV) begin
				d_mode = mcc_pkg::MODE_TAPER1; limit_mw = mcc_pkg::TAPER1_MW;
			end else begin
				d_mode = mcc_pkg::MODE_NORMAL;
			end
			if (d_mode != mcc_pkg::MODE_NORMAL) begin
				if (power_q >= limit_mw) begin
					if (d_duty > min_duty_q) d_duty = d_duty - 1'b1;
				end else if (d_duty < max_duty_q) begin
					d_duty = d_duty + 1'b1;
				end
			end else if (step_up_q) begin
				if (drop) begin
					fc = fc + 6'sd1;
					if (fc >= lim) begin
						fc        = '0;
						d_step_up = 1'b0;
					end
				end else begin
					fc = '0;
					// step up, direction holds only while there is headroom
					if (d_duty < max_duty_q) begin
						d_duty = d_duty + 1'b1;
						ret    = 1'b1;
					end
					d_step_up = ret;
				end
			end else begin
				if (drop) begin
					fc = fc - 6'sd1;
					if (fc <= -lim) begin
						fc        = '0;
						d_step_up = 1'b1;
					end
				end else begin
					fc = '0;
					// step down, turns around once the floor is reached
					ret = 1'b1;
					if (d_duty > min_duty_q) begin
						d_duty = d_duty - 1'b1;
						ret    = 1'b0;
					end
					d_step_up = ret;
				end
			end
		end
	end

	// result packing, lowest field first
	logic [OUT_W-1:0] pack;

	always_comb begin
		pack = '0;
		pack[78 + ENERGY_BITS:0] = {step_up_q, energy_q, batt_q, fin_ma_q[15:0],
			fin_mv_q[14:0], power_q, mode_q, duty_q};
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= mcc_pkg::S_IDLE;
			step_q       <= mcc_pkg::P_VIN_MUL;
			m_tvalid_q   <= 1'b0;
			min_duty_q   <= 8'd0;
			max_duty_q   <= 8'd127;
			max_power_q  <= 20'd12000;
			cutoff_q     <= 16'd7000;
			warn_q       <= 16'd7800;
			ctl_ivl_q    <= 16'd180;
			backoff_q    <= 20'd60000;
			fail_limit_q <= 4'd2;
			fin_mv_q     <= '0;
			fin_ma_q     <= '0;
			fout_q       <= '0;
			duty_q       <= 8'd6;
			power_q      <= '0;
			hist_a_q     <= '0;
			hist_b_q     <= '0;
			step_up_q    <= 1'b1;
			fail_q       <= '0;
			mode_q       <= mcc_pkg::MODE_NORMAL;
			last_ctl_q   <= '0;
			last_bo_q    <= '0;
			energy_q     <= '0;
		end else begin
			state_q <= state_n;

			// writes go straight in, upper data bits dropped
			if (cfg_valid) begin
				unique case (cfg_index)
					mcc_pkg::REG_MIN_DUTY:   min_duty_q   <= cfg_data[7:0];
					mcc_pkg::REG_MAX_DUTY:   max_duty_q   <= cfg_data[7:0];
					mcc_pkg::REG_MAX_POWER:  max_power_q  <= cfg_data;
					mcc_pkg::REG_CUTOFF:     cutoff_q     <= cfg_data[15:0];
					mcc_pkg::REG_WARN:       warn_q       <= cfg_data[15:0];
					mcc_pkg::REG_CTL_IVL:    ctl_ivl_q    <= cfg_data[15:0];
					mcc_pkg::REG_BACKOFF:    backoff_q    <= cfg_data;
					mcc_pkg::REG_FAIL_LIMIT: fail_limit_q <= cfg_data[3:0];
					default: ;
				endcase
			end

			if (state_q == mcc_pkg::S_IDLE && s_tvalid)
				step_q <= mcc_pkg::P_VIN_MUL;

			if (state_q == mcc_pkg::S_WAIT && done) begin
				step_q <= mcc_pkg::step_t'(step_q + 1'b1);
				unique case (step_q)
					mcc_pkg::P_CUR_DIV:
						// input voltage filter is a plain mean of two, both sides positive
						fin_mv_q <= 17'((18'(fin_mv_q) + 18'(in_mv_q)) >>> 1);
					mcc_pkg::P_FMA_DIV:  fin_ma_q <= res[16:0];
					mcc_pkg::P_FOUT_DIV: fout_q   <= res[16:0];
					mcc_pkg::P_BAT_DIV: begin
						// control decision due: record its time, clamp filters and shift power history
						if (ctl_due) begin
							last_ctl_q <= now;
							hist_b_q   <= hist_a_q;
							hist_a_q   <= power_q;
							if (fin_mv_q < 0) fin_mv_q <= '0;
							if (fin_ma_q < 0) fin_ma_q <= '0;
						end
					end
					mcc_pkg::P_PWR_DIV: power_q <= res[19:0];
					mcc_pkg::P_EGY_DIV:
						energy_q <= energy_q + ENERGY_BITS'(unsigned'(res));
					default: ;
				endcase
			end

			if (state_q == mcc_pkg::S_DECIDE) begin
				duty_q    <= d_duty;
				mode_q    <= d_mode;
				step_up_q <= d_step_up;
				fail_q    <= fc[4:0];
				if (d_bo_hit) last_bo_q <= now;
			end

			if (state_q == mcc_pkg::S_OUT && (!m_tvalid_q || m_tready))
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// payload and scratch registers
	always_ff @(posedge clk) begin
		if (state_q == mcc_pkg::S_IDLE && s_tvalid) begin
			time_q  <= s_tdata[31:0];
			adc_v_q <= s_tdata[41:32];
			adc_i_q <= s_tdata[51:42];
			adc_d_q <= s_tdata[61:52];
		end
		if (state_q == mcc_pkg::S_WAIT && done) begin
			unique case (step_q)
				mcc_pkg::P_VIN_DIV2: in_mv_q  <= res[15:0];
				mcc_pkg::P_DRP_DIV2: out_mv_q <= 17'(W'(in_mv_q) - res);
				mcc_pkg::P_CUR_DIV:  cur_ma_q <= res[16:0];
				// negative current estimate reads as zero
				mcc_pkg::P_OMA_DIV:  t_q <= (res < 0) ? '0 : res;
				mcc_pkg::P_BAT_DIV:  batt_q <= batt_c;
				default:             t_q <= res;
			endcase
		end
		if (state_q == mcc_pkg::S_OUT && (!m_tvalid_q || m_tready))
			m_tdata_q <= pack;
	end

	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign cfg_ready = 1'b1;

endmodule

// File: hw/rtl/mcc_checker.sv
// mcc_checker: port-level assertions on mppt_charge_controller
// depends on nothing; bound to the top level below
module mcc_checker #(
	parameter int ENERGY_BITS = 48
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [63:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [((79 + ENERGY_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [3:0]  cfg_index,
	input logic [19:0] cfg_data
);

	// a held result stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	// one item at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while busy");

	// a fresh result never shows in the cycle after an accept
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("result before work done");

	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[11:8] <= 4'd8)
		else $error("mode code out of range");

endmodule

bind mppt_charge_controller mcc_checker #(.ENERGY_BITS(ENERGY_BITS)) u_mcc_checker (.*);
